FILE: design/msjd_pkg.sv
// Package for the print job dispatcher: sizes, command and result codes,
// and the job, result and output stage control types.
// No dependencies.
package msjd_pkg;

  localparam int PRINTERS = 8;
  localparam int PIDX_W   = 3;
  localparam int PCNT_W   = 4;
  localparam int QDEPTH   = 16;
  localparam int QIDX_W   = 4;
  localparam int QCNT_W   = 5;
  localparam int TOTAL_W  = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

  localparam logic [2:0] CMD_SUBMIT = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_TICK   = 3'd2;
  localparam logic [2:0] CMD_FINISH = 3'd3;
  localparam logic [2:0] CMD_REPORT = 3'd4;

  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_REASGN = 3'd1;
  localparam logic [2:0] KIND_DONE   = 3'd2;
  localparam logic [2:0] KIND_ENTRY  = 3'd3;
  localparam logic [2:0] KIND_TOTAL  = 3'd4;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] pages;
  } job_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [PIDX_W-1:0]  printer;
    job_t               done;
    job_t               nxt;
    logic [TOTAL_W-1:0] total;
  } res_t;

  typedef struct packed {
    logic push;
    logic flush;
  } ostage_ctl_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } ostage_sts_t;

endpackage

FILE: design/msjd_if.sv
// Channel interfaces for the print job dispatcher: command input and result
// output, each with valid/ready and payload. Depends on nothing.
interface msjd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  job_id;
  logic [15:0] pages;

  modport source (output valid, cmd, job_id, pages, input ready);
  modport sink   (input valid, cmd, job_id, pages, output ready);
endinterface

interface msjd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  printer;
  logic [7:0]  done_job;
  logic [15:0] done_pages;
  logic [7:0]  new_job;
  logic [15:0] new_pages;
  logic [19:0] total_pages;
  logic        last;

  modport source (output valid, kind, printer, done_job, done_pages, new_job, new_pages,
                  total_pages, last, input ready);
  modport sink   (input valid, kind, printer, done_job, done_pages, new_job, new_pages,
                  total_pages, last, output ready);
endinterface

FILE: design/msjd_out_stage.sv
// Result output stage: holds one result back so the final one of a command
// can be tagged last, then drives the output register. Uses msjd_pkg, msjd_out_if.
module msjd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msjd_pkg::ostage_ctl_t ctl,
  input  msjd_pkg::res_t       res,
  output msjd_pkg::ostage_sts_t sts,
  msjd_out_if.source           out_ch
);

  logic           pend_vld_r, pend_vld_nxt;
  msjd_pkg::res_t pend_r;
  logic           out_vld_r, out_vld_nxt;
  msjd_pkg::res_t out_r;
  logic           out_last_r;
  logic           out_free;
  logic           move;

  assign out_free     = !out_vld_r || out_ch.ready;
  assign sts.push_ok  = !pend_vld_r || out_free;
  assign sts.flush_ok = !pend_vld_r || out_free;
  assign move         = pend_vld_r && out_free && (ctl.push || ctl.flush);

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    if (ctl.push && sts.push_ok) begin
      pend_vld_nxt = 1'b1;
    end else if (ctl.flush && sts.flush_ok) begin
      pend_vld_nxt = 1'b0;
    end
    out_vld_nxt = move ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && sts.push_ok) begin
      pend_r <= res;
    end
    if (move) begin
      out_r      <= pend_r;
      out_last_r <= ctl.flush && !ctl.push;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.printer     = out_r.printer;
  assign out_ch.done_job    = out_r.done.id;
  assign out_ch.done_pages  = out_r.done.pages;
  assign out_ch.new_job     = out_r.nxt.id;
  assign out_ch.new_pages   = out_r.nxt.pages;
  assign out_ch.total_pages = out_r.total;
  assign out_ch.last        = out_last_r;

endmodule

FILE: design/multi_server_job_dispatcher.sv
// Top level of the print job dispatcher: job queue and done stack memories,
// command sequencer and printer state. Uses msjd_pkg, msjd_if, msjd_out_stage.
//
// Usage: commands arrive on in_ch (valid/ready); a transfer happens when both
// are high. Submit queues a job (dropped if the queue is full) and produces no
// result; start, tick, finish and report each produce zero or more results on
// out_ch, the final one with last set. in_ch.ready is high only while no
// command is in progress. A submit, an unknown command or a tick on an empty
// queue never leaves idle. Start, tick and finish visit the printers in order
// from 0 up to num_printers-1 (num_printers taken as 1 if 0 and capped at 8),
// each with a queue memory read, then an update; start stops at the first idle
// printer that finds the queue empty. S_END then flushes the last result and
// returns to idle. Report emits the total, then reads and pops each done stack
// entry in turn, then ends through S_END. Results leave through a one-entry
// holding stage and an output register; a stall on out_ch.ready holds the
// sequencer without losing results.
// Reset: rst_n (synchronous, active low) empties the queue and done stack,
// idles all printers, clears the page total and sets num_printers to 8.
// cfg_we writes num_printers from cfg_wdata; write only while idle.
module multi_server_job_dispatcher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  msjd_in_if.sink    in_ch,
  msjd_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_RTOT = 3'd3;
  localparam logic [2:0] S_RRD  = 3'd4;
  localparam logic [2:0] S_RPOP = 3'd5;
  localparam logic [2:0] S_END  = 3'd6;

  localparam int PIDX_W  = msjd_pkg::PIDX_W;
  localparam int PCNT_W  = msjd_pkg::PCNT_W;
  localparam int QIDX_W  = msjd_pkg::QIDX_W;
  localparam int QCNT_W  = msjd_pkg::QCNT_W;
  localparam int TOTAL_W = msjd_pkg::TOTAL_W;

  msjd_pkg::job_t q_mem  [msjd_pkg::QDEPTH];
  msjd_pkg::job_t ds_mem [msjd_pkg::QDEPTH];
  msjd_pkg::job_t q_rd_r;
  msjd_pkg::job_t ds_rd_r;

  msjd_pkg::job_t cur_r  [msjd_pkg::PRINTERS];
  logic           busy_r [msjd_pkg::PRINTERS];
  logic [15:0]    left_r [msjd_pkg::PRINTERS];

  logic [2:0]         state_r, state_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [PIDX_W-1:0]  p_r, p_nxt;
  logic [QIDX_W-1:0]  head_r, head_nxt;
  logic [QIDX_W-1:0]  tail_r, tail_nxt;
  logic [QCNT_W-1:0]  q_cnt_r, q_cnt_nxt;
  logic [QCNT_W-1:0]  ds_cnt_r, ds_cnt_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [3:0]         num_r;

  logic [PCNT_W-1:0]  np;
  logic               p_last;
  logic               in_fire;
  logic [TOTAL_W:0]   sum;
  logic [QIDX_W-1:0]  ds_rd_addr;
  logic               q_ne;
  logic               q_wr;
  logic               ds_wr;
  logic               p_wr;
  logic               cur_busy;
  logic [15:0]        cur_left;

  logic               emit, do_pop, do_done, set_job, clr_busy, clr_left, adv, go_end;
  logic               got;
  logic               busy_new;
  logic [15:0]        left_base, left_new;

  msjd_pkg::res_t      res;
  msjd_pkg::ostage_ctl_t ctl;
  msjd_pkg::ostage_sts_t sts;

  always_comb begin
    if (num_r == 4'd0) begin
      np = PCNT_W'(1);
    end else if (num_r > 4'(msjd_pkg::PRINTERS)) begin
      np = PCNT_W'(msjd_pkg::PRINTERS);
    end else begin
      np = num_r;
    end
  end

  assign p_last      = ({1'b0, p_r} == (np - PCNT_W'(1)));
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign sum         = {1'b0, total_r} + (TOTAL_W+1)'(in_ch.pages);
  assign ds_rd_addr  = QIDX_W'(ds_cnt_r - QCNT_W'(1));
  assign q_ne        = (q_cnt_r != '0);
  assign cur_busy    = busy_r[p_r];
  assign cur_left    = left_r[p_r];

  // Per-printer decision in the update cycle.
  always_comb begin
    emit     = 1'b0;
    do_pop   = 1'b0;
    do_done  = 1'b0;
    set_job  = 1'b0;
    clr_busy = 1'b0;
    clr_left = 1'b0;
    adv      = 1'b0;
    go_end   = 1'b0;
    got      = 1'b0;
    res      = '0;
    res.printer = p_r;
    unique case (cmd_r)
      msjd_pkg::CMD_START: begin
        if (cur_busy) begin
          adv = 1'b1;
        end else if (!q_ne) begin
          go_end = 1'b1;
        end else begin
          emit     = 1'b1;
          res.kind = msjd_pkg::KIND_START;
          res.nxt  = q_rd_r;
          do_pop   = 1'b1;
          set_job  = 1'b1;
          adv      = 1'b1;
        end
      end
      msjd_pkg::CMD_TICK: begin
        adv = 1'b1;
        if (cur_left == '0) begin
          got = q_ne;
          if (cur_busy) begin
            do_done  = 1'b1;
            emit     = 1'b1;
            res.done = cur_r[p_r];
            if (got) begin
              res.kind = msjd_pkg::KIND_REASGN;
              res.nxt  = q_rd_r;
            end else begin
              res.kind = msjd_pkg::KIND_DONE;
              clr_busy = 1'b1;
            end
          end else if (got) begin
            emit     = 1'b1;
            res.kind = msjd_pkg::KIND_START;
            res.nxt  = q_rd_r;
          end
          if (got) begin
            do_pop  = 1'b1;
            set_job = 1'b1;
          end
        end
      end
      msjd_pkg::CMD_FINISH: begin
        adv = 1'b1;
        if (cur_busy) begin
          do_done  = 1'b1;
          emit     = 1'b1;
          res.kind = msjd_pkg::KIND_DONE;
          res.done = cur_r[p_r];
          clr_busy = 1'b1;
          clr_left = 1'b1;
        end
      end
      default: begin
        go_end = 1'b1;
      end
    endcase

    if (state_r == S_RTOT) begin
      res      = '0;
      res.kind = msjd_pkg::KIND_TOTAL;
      res.total = total_r;
    end else if (state_r == S_RPOP) begin
      res      = '0;
      res.kind = msjd_pkg::KIND_ENTRY;
      res.done = ds_rd_r;
    end

    busy_new  = set_job ? 1'b1 : (clr_busy ? 1'b0 : cur_busy);
    left_base = set_job ? q_rd_r.pages : (clr_left ? 16'd0 : cur_left);
    if (cmd_r == msjd_pkg::CMD_TICK && busy_new && left_base != '0) begin
      left_new = left_base - 16'd1;
    end else begin
      left_new = left_base;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    p_nxt      = p_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    q_cnt_nxt  = q_cnt_r;
    ds_cnt_nxt = ds_cnt_r;
    total_nxt  = total_r;
    q_wr       = 1'b0;
    ds_wr      = 1'b0;
    p_wr       = 1'b0;
    ctl        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_ch.cmd;
          p_nxt   = '0;
          priority if (in_ch.cmd == msjd_pkg::CMD_SUBMIT) begin
            if (q_cnt_r < QCNT_W'(msjd_pkg::QDEPTH)) begin
              q_wr      = 1'b1;
              tail_nxt  = tail_r + QIDX_W'(1);
              q_cnt_nxt = q_cnt_r + QCNT_W'(1);
              total_nxt = (sum > (TOTAL_W+1)'(msjd_pkg::TOTAL_MAX)) ? msjd_pkg::TOTAL_MAX
                                                                    : sum[TOTAL_W-1:0];
            end
          end else if (in_ch.cmd == msjd_pkg::CMD_START ||
                       in_ch.cmd == msjd_pkg::CMD_FINISH) begin
            state_nxt = S_RD;
          end else if (in_ch.cmd == msjd_pkg::CMD_TICK) begin
            if (q_ne) begin
              state_nxt = S_RD;
            end
          end else if (in_ch.cmd == msjd_pkg::CMD_REPORT) begin
            state_nxt = S_RTOT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EX;
      end
      S_EX: begin
        ctl.push = emit;
        if (!emit || sts.push_ok) begin
          if (go_end) begin
            state_nxt = S_END;
          end else begin
            p_wr = 1'b1;
            if (do_pop) begin
              head_nxt  = head_r + QIDX_W'(1);
              q_cnt_nxt = q_cnt_r - QCNT_W'(1);
            end
            if (do_done && ds_cnt_r < QCNT_W'(msjd_pkg::QDEPTH)) begin
              ds_wr      = 1'b1;
              ds_cnt_nxt = ds_cnt_r + QCNT_W'(1);
            end
            if (adv) begin
              if (p_last) begin
                state_nxt = S_END;
              end else begin
                p_nxt     = p_r + PIDX_W'(1);
                state_nxt = S_RD;
              end
            end
          end
        end
      end
      S_RTOT: begin
        ctl.push = 1'b1;
        if (sts.push_ok) begin
          state_nxt = (ds_cnt_r != '0) ? S_RRD : S_END;
        end
      end
      S_RRD: begin
        state_nxt = S_RPOP;
      end
      S_RPOP: begin
        ctl.push = 1'b1;
        if (sts.push_ok) begin
          ds_cnt_nxt = ds_cnt_r - QCNT_W'(1);
          state_nxt  = (ds_cnt_r == QCNT_W'(1)) ? S_END : S_RRD;
        end
      end
      S_END: begin
        ctl.flush = 1'b1;
        if (sts.flush_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cmd_r    <= msjd_pkg::CMD_SUBMIT;
      p_r      <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      q_cnt_r  <= '0;
      ds_cnt_r <= '0;
      total_r  <= '0;
      num_r    <= 4'd8;
    end else begin
      state_r  <= state_nxt;
      cmd_r    <= cmd_nxt;
      p_r      <= p_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      q_cnt_r  <= q_cnt_nxt;
      ds_cnt_r <= ds_cnt_nxt;
      total_r  <= total_nxt;
      if (cfg_we) begin
        num_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < msjd_pkg::PRINTERS; i++) begin
        busy_r[i] <= 1'b0;
        left_r[i] <= '0;
      end
    end else if (p_wr) begin
      busy_r[p_r] <= busy_new;
      left_r[p_r] <= left_new;
    end
  end

  always_ff @(posedge clk) begin
    if (p_wr && set_job) begin
      cur_r[p_r] <= q_rd_r;
    end
  end

  // Job queue memory.
  always_ff @(posedge clk) begin
    if (q_wr) begin
      q_mem[tail_r] <= '{id: in_ch.job_id, pages: in_ch.pages};
    end
    q_rd_r <= q_mem[head_r];
  end

  // Done stack memory.
  always_ff @(posedge clk) begin
    if (ds_wr) begin
      ds_mem[ds_cnt_r[QIDX_W-1:0]] <= cur_r[p_r];
    end
    ds_rd_r <= ds_mem[ds_rd_addr];
  end

  msjd_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .res    (res),
    .sts    (sts),
    .out_ch (out_ch)
  );

endmodule
